/* hdl/phfe_pkg.sv */
package phfe_pkg;

	// Ethertypes
	localparam logic [15:0] ET_IPV4     = 16'h0800;
	localparam logic [15:0] ET_IPV6     = 16'h86DD;
	localparam logic [15:0] ET_ARP      = 16'h0806;
	localparam logic [15:0] ET_PPP_DISC = 16'h8863;
	localparam logic [15:0] ET_PPP_SES  = 16'h8864;

	// PPP protocol numbers inside a PPPoE session
	localparam logic [15:0] PPP_IPV4 = 16'h0021;
	localparam logic [15:0] PPP_IPV6 = 16'h0057;

	// Layer 4 protocol numbers
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [7:0] NH_NONE   = 8'd59;

	// Byte positions within the frame
	localparam logic [6:0] POS_MAX      = 7'd127;
	localparam logic [6:0] POS_ETYPE_HI = 7'd12;
	localparam logic [6:0] POS_ETYPE_LO = 7'd13;
	localparam logic [6:0] POS_PPP_HI   = 7'd20;
	localparam logic [6:0] POS_PPP_LO   = 7'd21;

	// Header lengths
	localparam logic [7:0] ETH_LEN   = 8'd14;
	localparam logic [7:0] PPPOE_LEN = 8'd8;
	localparam logic [7:0] V4_LEN    = 8'd20;
	localparam logic [7:0] V6_LEN    = 8'd40;
	localparam logic [7:0] TCP_LEN   = 8'd20;
	localparam logic [7:0] UDP_LEN   = 8'd8;

	// Verdict codes
	localparam logic [1:0] VERDICT_PASS   = 2'd0;
	localparam logic [1:0] VERDICT_DROP   = 2'd1;
	localparam logic [1:0] VERDICT_RECORD = 2'd2;

	// Raw fields of one finished frame, handed from parser to result stage
	typedef struct packed {
		logic [7:0]  frame_len;
		logic        pppoe;
		logic [15:0] ethertype;
		logic [7:0]  ip_proto;
		logic [31:0] v4_src;
		logic [31:0] v4_dst;
		logic [63:0] v6_src_hi;
		logic [63:0] v6_src_lo;
		logic [63:0] v6_dst_hi;
		logic [63:0] v6_dst_lo;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] ifidx;
	} phfe_rec_t;

endpackage

/* hdl/phfe_ifs.sv */
interface phfe_frame_if;
	logic        valid;
	logic        ready;
	logic [7:0]  frame_byte;
	logic        last_byte;
	logic [31:0] ifindex;

	modport source(output valid, frame_byte, last_byte, ifindex, input ready);
	modport sink(input valid, frame_byte, last_byte, ifindex, output ready);
endinterface

interface phfe_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [15:0] l3_protocol;
	logic [7:0]  l4_protocol;
	logic [31:0] ipv4_source;
	logic [31:0] ipv4_destination;
	logic [63:0] ipv6_source_high;
	logic [63:0] ipv6_source_low;
	logic [63:0] ipv6_destination_high;
	logic [63:0] ipv6_destination_low;
	logic [15:0] source_port;
	logic [15:0] destination_port;
	logic [31:0] interface_index;

	modport source(output valid, verdict, l3_protocol, l4_protocol, ipv4_source,
		ipv4_destination, ipv6_source_high, ipv6_source_low, ipv6_destination_high,
		ipv6_destination_low, source_port, destination_port, interface_index,
		input ready);
	modport sink(input valid, verdict, l3_protocol, l4_protocol, ipv4_source,
		ipv4_destination, ipv6_source_high, ipv6_source_low, ipv6_destination_high,
		ipv6_destination_low, source_port, destination_port, interface_index,
		output ready);
endinterface

/* hdl/packet_header_field_extractor.sv */
// Ethernet header parser: takes a frame one byte per cycle and gives one result
// per frame, once its record leaves the queue, holding a verdict (pass, drop or
// record) and the extracted Ethernet, optional PPPoE session, IPv4/IPv6 and
// TCP/UDP fields. A byte is taken every cycle; the input stalls only when the
// frame queue between the byte parser and the result register is full
// (QUEUE_DEPTH finished frames waiting while the result side is held), so a
// run of frames shorter than that backlog is never throttled. IPv4 options are
// not skipped: layer 4 is assumed to start right after the 20-byte header.
module packet_header_field_extractor #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	phfe_frame_if.sink    frame,
	phfe_result_if.source result
);
	import phfe_pkg::*;

	logic      rec_push, rec_full, rec_pop, rec_valid;
	phfe_rec_t rec_in, rec_out;

	// Byte parser
	phfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame),
		.rec_full (rec_full),
		.rec_push (rec_push),
		.rec_data (rec_in)
	);

	// Frame record queue
	phfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.push_data (rec_in),
		.full      (rec_full),
		.pop       (rec_pop),
		.not_empty (rec_valid),
		.pop_data  (rec_out)
	);

	// Verdict and result register
	phfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec       (rec_out),
		.rec_pop   (rec_pop),
		.result    (result)
	);

endmodule

/* hdl/phfe_front.sv */
module phfe_front (
	input  logic                clk,
	input  logic                arst_n,
	phfe_frame_if.sink          frame,
	input  logic                rec_full,
	output logic                rec_push,
	output phfe_pkg::phfe_rec_t rec_data
);
	import phfe_pkg::*;

	logic [6:0]  pos_q;
	logic [15:0] etype_q, etype_d;
	logic        pppoe_q, pppoe_d;
	logic [7:0]  proto_q, proto_d;
	logic [31:0] v4s_q, v4s_d, v4d_q, v4d_d;
	logic [63:0] v6sh_q, v6sh_d, v6sl_q, v6sl_d, v6dh_q, v6dh_d, v6dl_q, v6dl_d;
	logic [15:0] sport_q, sport_d, dport_q, dport_d;
	logic [31:0] ifidx_q, ifidx_d;
	logic [7:0]  base;
	logic [7:0]  rel;
	logic [7:0]  b;
	logic        accept;

	assign b           = frame.frame_byte;
	assign frame.ready = !rec_full;
	assign accept      = frame.valid && frame.ready;

	// Latch the current byte into whichever header field sits at this position
	always_comb begin
		etype_d = etype_q;
		pppoe_d = pppoe_q;
		proto_d = proto_q;
		v4s_d   = v4s_q;
		v4d_d   = v4d_q;
		v6sh_d  = v6sh_q;
		v6sl_d  = v6sl_q;
		v6dh_d  = v6dh_q;
		v6dl_d  = v6dl_q;
		sport_d = sport_q;
		dport_d = dport_q;
		ifidx_d = (pos_q == '0) ? frame.ifindex : ifidx_q;
		base    = pppoe_q ? (ETH_LEN + PPPOE_LEN) : ETH_LEN;
		rel     = {1'b0, pos_q} - base;
		if (pos_q == '0) begin
			// interface index only
		end else if (pos_q == POS_ETYPE_HI) begin
			etype_d = {b, 8'h00};
		end else if (pos_q == POS_ETYPE_LO) begin
			etype_d = {etype_q[15:8], b};
			if (etype_d == ET_PPP_SES) begin
				pppoe_d = 1'b1;
			end
		end else if (pppoe_q && pos_q == POS_PPP_HI) begin
			proto_d = b;
		end else if (pppoe_q && pos_q == POS_PPP_LO) begin
			proto_d = '0;
			case ({proto_q, b})
				PPP_IPV4: etype_d = ET_IPV4;
				PPP_IPV6: etype_d = ET_IPV6;
				default:  etype_d = '0;
			endcase
		end else if ({1'b0, pos_q} >= base) begin
			if (etype_q == ET_IPV4) begin
				if (rel == 8'd9) begin
					proto_d = b;
				end else if (rel >= 8'd12 && rel < 8'd16) begin
					v4s_d = {v4s_q[23:0], b};
				end else if (rel >= 8'd16 && rel < V4_LEN) begin
					v4d_d = {v4d_q[23:0], b};
				end else if (rel >= V4_LEN && rel < V4_LEN + 8'd2) begin
					sport_d = {sport_q[7:0], b};
				end else if (rel >= V4_LEN + 8'd2 && rel < V4_LEN + 8'd4) begin
					dport_d = {dport_q[7:0], b};
				end
			end else if (etype_q == ET_IPV6) begin
				if (rel == 8'd6) begin
					proto_d = b;
				end else if (rel >= 8'd8 && rel < 8'd16) begin
					v6sh_d = {v6sh_q[55:0], b};
				end else if (rel >= 8'd16 && rel < 8'd24) begin
					v6sl_d = {v6sl_q[55:0], b};
				end else if (rel >= 8'd24 && rel < 8'd32) begin
					v6dh_d = {v6dh_q[55:0], b};
				end else if (rel >= 8'd32 && rel < V6_LEN) begin
					v6dl_d = {v6dl_q[55:0], b};
				end else if (rel >= V6_LEN && rel < V6_LEN + 8'd2) begin
					sport_d = {sport_q[7:0], b};
				end else if (rel >= V6_LEN + 8'd2 && rel < V6_LEN + 8'd4) begin
					dport_d = {dport_q[7:0], b};
				end
			end
		end
	end

	// Hand the finished frame to the queue on its last byte
	assign rec_push = accept && frame.last_byte;
	always_comb begin
		rec_data.frame_len = {1'b0, pos_q} + 8'd1;
		rec_data.pppoe     = pppoe_d;
		rec_data.ethertype = etype_d;
		rec_data.ip_proto  = proto_d;
		rec_data.v4_src    = v4s_d;
		rec_data.v4_dst    = v4d_d;
		rec_data.v6_src_hi = v6sh_d;
		rec_data.v6_src_lo = v6sl_d;
		rec_data.v6_dst_hi = v6dh_d;
		rec_data.v6_dst_lo = v6dl_d;
		rec_data.src_port  = sport_d;
		rec_data.dst_port  = dport_d;
		rec_data.ifidx     = ifidx_d;
	end

	// Advance the parse state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			etype_q <= '0;
			pppoe_q <= 1'b0;
			proto_q <= '0;
			v4s_q   <= '0;
			v4d_q   <= '0;
			v6sh_q  <= '0;
			v6sl_q  <= '0;
			v6dh_q  <= '0;
			v6dl_q  <= '0;
			sport_q <= '0;
			dport_q <= '0;
			ifidx_q <= '0;
		end else if (accept) begin
			if (frame.last_byte) begin
				pos_q   <= '0;
				etype_q <= '0;
				pppoe_q <= 1'b0;
				proto_q <= '0;
				v4s_q   <= '0;
				v4d_q   <= '0;
				v6sh_q  <= '0;
				v6sl_q  <= '0;
				v6dh_q  <= '0;
				v6dl_q  <= '0;
				sport_q <= '0;
				dport_q <= '0;
				ifidx_q <= '0;
			end else begin
				pos_q   <= (pos_q < POS_MAX) ? pos_q + 7'd1 : POS_MAX;
				etype_q <= etype_d;
				pppoe_q <= pppoe_d;
				proto_q <= proto_d;
				v4s_q   <= v4s_d;
				v4d_q   <= v4d_d;
				v6sh_q  <= v6sh_d;
				v6sl_q  <= v6sl_d;
				v6dh_q  <= v6dh_d;
				v6dl_q  <= v6dl_d;
				sport_q <= sport_d;
				dport_q <= dport_d;
				ifidx_q <= ifidx_d;
			end
		end
	end

endmodule

/* hdl/phfe_queue.sv */
module phfe_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  phfe_pkg::phfe_rec_t push_data,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output phfe_pkg::phfe_rec_t pop_data
);
	import phfe_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	phfe_rec_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	// Store incoming frame records
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/phfe_back.sv */
module phfe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_valid,
	input  phfe_pkg::phfe_rec_t rec,
	output logic                rec_pop,
	phfe_result_if.source       result
);
	import phfe_pkg::*;

	logic [7:0]  base_len, l3_len, l4_len;
	logic        is_v4, is_v6;
	logic [1:0]  verdict;
	logic        keep_l3, keep_l4, keep_v4, keep_v6, keep_if;
	logic        valid_q;
	logic        load;

	// Decide the verdict and which fields survive
	always_comb begin
		is_v4    = (rec.ethertype == ET_IPV4);
		is_v6    = (rec.ethertype == ET_IPV6);
		base_len = rec.pppoe ? (ETH_LEN + PPPOE_LEN) : ETH_LEN;
		l3_len   = is_v6 ? V6_LEN : V4_LEN;
		l4_len   = (rec.ip_proto == PROTO_TCP) ? TCP_LEN : UDP_LEN;
		verdict  = VERDICT_PASS;
		keep_l3  = 1'b0;
		keep_l4  = 1'b0;
		keep_v4  = 1'b0;
		keep_v6  = 1'b0;
		keep_if  = 1'b0;
		if (rec.frame_len < ETH_LEN || (rec.pppoe && rec.frame_len < base_len)) begin
			verdict = VERDICT_PASS;
		end else if (rec.ethertype == ET_ARP || rec.ethertype == ET_PPP_DISC) begin
			verdict = VERDICT_RECORD;
			keep_l3 = 1'b1;
			keep_if = 1'b1;
		end else if ((is_v4 || is_v6) && rec.frame_len >= base_len + l3_len) begin
			if (is_v6 && rec.ip_proto == NH_NONE) begin
				verdict = VERDICT_DROP;
			end else if ((rec.ip_proto == PROTO_TCP || rec.ip_proto == PROTO_UDP)
					&& rec.frame_len >= base_len + l3_len + l4_len) begin
				verdict = VERDICT_RECORD;
				keep_l3 = 1'b1;
				keep_l4 = 1'b1;
				keep_v4 = is_v4;
				keep_v6 = is_v6;
				keep_if = 1'b1;
			end
		end
	end

	// Load the output register when it is empty or being drained
	assign load    = rec_valid && (!valid_q || result.ready);
	assign rec_pop = load;
	assign result.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result.verdict               <= verdict;
			result.l3_protocol           <= keep_l3 ? rec.ethertype : '0;
			result.l4_protocol           <= keep_l4 ? rec.ip_proto : '0;
			result.ipv4_source           <= keep_v4 ? rec.v4_src : '0;
			result.ipv4_destination      <= keep_v4 ? rec.v4_dst : '0;
			result.ipv6_source_high      <= keep_v6 ? rec.v6_src_hi : '0;
			result.ipv6_source_low       <= keep_v6 ? rec.v6_src_lo : '0;
			result.ipv6_destination_high <= keep_v6 ? rec.v6_dst_hi : '0;
			result.ipv6_destination_low  <= keep_v6 ? rec.v6_dst_lo : '0;
			result.source_port           <= keep_l4 ? rec.src_port : '0;
			result.destination_port      <= keep_l4 ? rec.dst_port : '0;
			result.interface_index       <= keep_if ? rec.ifidx : '0;
		end
	end

endmodule

/* test/packet_header_field_extractor_tb.sv */
`timescale 1ns / 100ps

module packet_header_field_extractor_tb;

	import phfe_pkg::*;

	localparam int unsigned RANDOM_BYTES  = 470;
	localparam int unsigned RANDOM_FRAMES = 6;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned DRAIN_CYCLES  = 16;
	localparam int unsigned MAX_PRINTED   = 50;
	localparam logic [7:0]  PROTO_ICMP    = 8'd1;
	localparam logic [15:0] PPP_UNKNOWN   = 16'h0023;
	localparam logic [15:0] ET_UNKNOWN    = 16'h1234;

	// One byte transaction on the frame channel
	typedef struct {
		logic [7:0]  data;
		logic        last;
		logic [31:0] ifidx;
	} frame_byte_t;

	// Fields of one per-frame result
	typedef struct packed {
		logic [1:0]  verdict;
		logic [15:0] l3;
		logic [7:0]  l4;
		logic [31:0] v4_src;
		logic [31:0] v4_dst;
		logic [63:0] v6_src_hi;
		logic [63:0] v6_src_lo;
		logic [63:0] v6_dst_hi;
		logic [63:0] v6_dst_lo;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] ifidx;
	} hdr_summary_t;

	logic clk = 1'b0;
	logic arst_n;

	phfe_frame_if  frame_ch ();
	phfe_result_if result_ch ();

	packet_header_field_extractor u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch)
	);

	// Clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	frame_byte_t  pending_bytes[$];
	hdr_summary_t expected_hdrs[$];
	int unsigned  total_bytes;
	int unsigned  bytes_taken;
	int unsigned  error_cnt;
	int unsigned  cycle_cnt;
	int unsigned  src_idle_pct;
	int unsigned  snk_idle_pct;

	// Parser state tracked alongside the block
	logic [6:0]  pos_cnt;
	logic [15:0] etype;
	logic        in_session;
	logic [7:0]  proto;
	logic [31:0] v4_src;
	logic [31:0] v4_dst;
	logic [63:0] v6_src[2];
	logic [63:0] v6_dst[2];
	logic [15:0] sport;
	logic [15:0] dport;
	logic [31:0] if_reg;

	task automatic clear_parser();
		pos_cnt    = '0;
		etype      = '0;
		in_session = 1'b0;
		proto      = '0;
		v4_src     = '0;
		v4_dst     = '0;
		v6_src[0]  = '0;
		v6_src[1]  = '0;
		v6_dst[0]  = '0;
		v6_dst[1]  = '0;
		sport      = '0;
		dport      = '0;
		if_reg     = '0;
	endtask

	task automatic report_mismatch(input string what);
		if (error_cnt < MAX_PRINTED)
			$display("ERROR @%0t: %s", $time, what);
		error_cnt++;
	endtask

	// Latch a layer 4 port byte, q counted from the start of the layer 4 header
	task automatic latch_port(input logic [7:0] q, input logic [7:0] b);
		if (q < 8'd2)
			sport = {sport[7:0], b};
		else if (q < 8'd4)
			dport = {dport[7:0], b};
	endtask

	// Advance the parser by one accepted byte; queue a result on the last byte
	task automatic parse_byte(input logic [7:0] b, input logic last, input logic [31:0] ifi);
		logic [6:0]   p;
		logic [7:0]   hdr_base;
		logic [7:0]   r;
		logic [7:0]   len;
		logic [7:0]   l3len;
		logic [7:0]   need;
		logic [15:0]  ppp;
		hdr_summary_t res;

		p = pos_cnt;
		if (p == 7'd0)
			if_reg = ifi;
		hdr_base = in_session ? ETH_LEN + PPPOE_LEN : ETH_LEN;

		// latch the byte into whichever field it belongs to
		if (p == 7'd0) begin
		end else if (p == POS_ETYPE_HI) begin
			etype = {b, 8'h00};
		end else if (p == POS_ETYPE_LO) begin
			etype[7:0] = b;
			if (etype == ET_PPP_SES)
				in_session = 1'b1;
		end else if (in_session && p == POS_PPP_HI) begin
			proto = b;
		end else if (in_session && p == POS_PPP_LO) begin
			ppp = {proto, b};
			proto = '0;
			if (ppp == PPP_IPV4)
				etype = ET_IPV4;
			else if (ppp == PPP_IPV6)
				etype = ET_IPV6;
			else
				etype = '0;
		end else if ({1'b0, p} >= hdr_base) begin
			r = {1'b0, p} - hdr_base;
			if (etype == ET_IPV4) begin
				if (r == 8'd9)
					proto = b;
				else if (r >= 8'd12 && r < 8'd16)
					v4_src = {v4_src[23:0], b};
				else if (r >= 8'd16 && r < 8'd20)
					v4_dst = {v4_dst[23:0], b};
				else if (r >= V4_LEN)
					latch_port(r - V4_LEN, b);
			end else if (etype == ET_IPV6) begin
				if (r == 8'd6)
					proto = b;
				else if (r >= 8'd8 && r < 8'd16)
					v6_src[0] = {v6_src[0][55:0], b};
				else if (r >= 8'd16 && r < 8'd24)
					v6_src[1] = {v6_src[1][55:0], b};
				else if (r >= 8'd24 && r < 8'd32)
					v6_dst[0] = {v6_dst[0][55:0], b};
				else if (r >= 8'd32 && r < 8'd40)
					v6_dst[1] = {v6_dst[1][55:0], b};
				else if (r >= V6_LEN)
					latch_port(r - V6_LEN, b);
			end
		end

		if (!last) begin
			pos_cnt = (p < POS_MAX) ? p + 7'd1 : POS_MAX;
			return;
		end

		// decide the verdict for the finished frame
		res = '0;
		len = {1'b0, p} + 8'd1;
		hdr_base = in_session ? ETH_LEN + PPPOE_LEN : ETH_LEN;
		if (len < ETH_LEN || (in_session && len < hdr_base)) begin
		end else if (etype == ET_ARP || etype == ET_PPP_DISC) begin
			res.verdict = VERDICT_RECORD;
			res.l3      = etype;
			res.ifidx   = if_reg;
		end else if (etype == ET_IPV4 || etype == ET_IPV6) begin
			l3len = (etype == ET_IPV4) ? V4_LEN : V6_LEN;
			need  = (proto == PROTO_TCP) ? TCP_LEN : UDP_LEN;
			if (len < hdr_base + l3len) begin
			end else if (etype == ET_IPV6 && proto == NH_NONE) begin
				res.verdict = VERDICT_DROP;
			end else if ((proto == PROTO_TCP || proto == PROTO_UDP)
					&& len >= hdr_base + l3len + need) begin
				res.verdict = VERDICT_RECORD;
				res.l3      = etype;
				res.l4      = proto;
				if (etype == ET_IPV4) begin
					res.v4_src = v4_src;
					res.v4_dst = v4_dst;
				end else begin
					res.v6_src_hi = v6_src[0];
					res.v6_src_lo = v6_src[1];
					res.v6_dst_hi = v6_dst[0];
					res.v6_dst_lo = v6_dst[1];
				end
				res.sport = sport;
				res.dport = dport;
				res.ifidx = if_reg;
			end
		end
		expected_hdrs.push_back(res);
		clear_parser();
	endtask

	task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	// Compare one accepted result against the oldest expectation
	task automatic check_result();
		hdr_summary_t want;

		if (expected_hdrs.size() == 0) begin
			report_mismatch("result transaction with no frame outstanding");
			return;
		end
		want = expected_hdrs.pop_front();
		cmp_field("verdict", 64'(result_ch.verdict), 64'(want.verdict));
		cmp_field("l3_protocol", 64'(result_ch.l3_protocol), 64'(want.l3));
		cmp_field("l4_protocol", 64'(result_ch.l4_protocol), 64'(want.l4));
		cmp_field("ipv4_source", 64'(result_ch.ipv4_source), 64'(want.v4_src));
		cmp_field("ipv4_destination", 64'(result_ch.ipv4_destination), 64'(want.v4_dst));
		cmp_field("ipv6_source_high", result_ch.ipv6_source_high, want.v6_src_hi);
		cmp_field("ipv6_source_low", result_ch.ipv6_source_low, want.v6_src_lo);
		cmp_field("ipv6_destination_high", result_ch.ipv6_destination_high, want.v6_dst_hi);
		cmp_field("ipv6_destination_low", result_ch.ipv6_destination_low, want.v6_dst_lo);
		cmp_field("source_port", 64'(result_ch.source_port), 64'(want.sport));
		cmp_field("destination_port", 64'(result_ch.destination_port), 64'(want.dport));
		cmp_field("interface_index", 64'(result_ch.interface_index), 64'(want.ifidx));
	endtask

	// Build one frame from its header choices, cut or padded to len bytes
	task automatic queue_frame(input logic [15:0] etype_f, input logic [15:0] ppp_f,
			input logic [7:0] l4, input int unsigned len, input logic [31:0] first_if);
		logic [7:0]  hdr[$];
		logic [15:0] l3;
		frame_byte_t item;

		repeat (12) hdr.push_back(8'($urandom_range(255)));
		hdr.push_back(etype_f[15:8]);
		hdr.push_back(etype_f[7:0]);
		l3 = etype_f;
		if (etype_f == ET_PPP_SES) begin
			repeat (6) hdr.push_back(8'($urandom_range(255)));
			hdr.push_back(ppp_f[15:8]);
			hdr.push_back(ppp_f[7:0]);
			l3 = (ppp_f == PPP_IPV4) ? ET_IPV4 : (ppp_f == PPP_IPV6) ? ET_IPV6 : 16'h0000;
		end
		if (l3 == ET_IPV4) begin
			for (int i = 0; i < V4_LEN; i++)
				hdr.push_back((i == 9) ? l4 : 8'($urandom_range(255)));
		end else if (l3 == ET_IPV6) begin
			for (int i = 0; i < V6_LEN; i++)
				hdr.push_back((i == 6) ? l4 : 8'($urandom_range(255)));
		end
		while (hdr.size() < len)
			hdr.push_back(8'($urandom_range(255)));
		for (int i = 0; i < len; i++) begin
			item.data  = hdr[i];
			item.last  = (i == len - 1);
			item.ifidx = (i == 0) ? first_if : $urandom;
			pending_bytes.push_back(item);
		end
		total_bytes += len;
	endtask

	// Drive frame bytes and track each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		frame_byte_t nxt;

		if (!arst_n) begin
			frame_ch.valid      <= 1'b0;
			frame_ch.frame_byte <= '0;
			frame_ch.last_byte  <= 1'b0;
			frame_ch.ifindex    <= '0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				parse_byte(frame_ch.frame_byte, frame_ch.last_byte, frame_ch.ifindex);
				bytes_taken++;
			end
			// switch idling pattern by thirds of the run
			if (bytes_taken * 3 < total_bytes) begin
				src_idle_pct <= 27;
				snk_idle_pct <= 81;
			end else if (bytes_taken * 3 < total_bytes * 2) begin
				src_idle_pct <= 81;
				snk_idle_pct <= 27;
			end else begin
				src_idle_pct <= 0;
				snk_idle_pct <= 0;
			end
			// hold while stalled, else offer the next byte or idle
			if (!frame_ch.valid || frame_ch.ready) begin
				if (pending_bytes.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					nxt = pending_bytes.pop_front();
					frame_ch.valid      <= 1'b1;
					frame_ch.frame_byte <= nxt.data;
					frame_ch.last_byte  <= nxt.last;
					frame_ch.ifindex    <= nxt.ifidx;
				end else begin
					frame_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Accept results with random backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready)
				check_result();
			result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk)
		cycle_cnt <= cycle_cnt + 1;

	initial begin
		int unsigned rand_bytes;
		int unsigned rand_frames;
		int unsigned sel;
		int unsigned len;
		int unsigned full;
		logic        session;
		logic [15:0] l3;
		logic [15:0] etype_f;
		logic [15:0] ppp_f;
		logic [7:0]  l4;

		arst_n              = 1'b0;
		frame_ch.valid      = 1'b0;
		frame_ch.frame_byte = '0;
		frame_ch.last_byte  = 1'b0;
		frame_ch.ifindex    = '0;
		result_ch.ready     = 1'b0;
		total_bytes  = 0;
		bytes_taken  = 0;
		error_cnt    = 0;
		cycle_cnt    = 0;
		src_idle_pct = 27;
		snk_idle_pct = 81;
		rand_bytes   = 0;
		rand_frames  = 0;
		clear_parser();

		// directed frames: boundaries of every header and every protocol
		queue_frame(ET_IPV4, PPP_IPV4, PROTO_TCP, 1, 32'hFFFF_FFFF);
		queue_frame(ET_IPV4, PPP_IPV4, PROTO_TCP, 13, 32'h0000_0000);
		queue_frame(ET_ARP, PPP_IPV4, PROTO_TCP, 14, 32'hFFFF_FFFF);
		queue_frame(ET_PPP_DISC, PPP_IPV4, PROTO_TCP, 20, $urandom);
		queue_frame(ET_PPP_SES, PPP_IPV4, PROTO_TCP, 21, $urandom);
		queue_frame(ET_PPP_SES, PPP_IPV4, PROTO_TCP, 62, 32'h0000_0000);
		queue_frame(ET_PPP_SES, PPP_IPV6, PROTO_UDP, 70, 32'hFFFF_FFFF);
		queue_frame(ET_PPP_SES, PPP_UNKNOWN, PROTO_UDP, 70, $urandom);
		queue_frame(ET_PPP_SES, PPP_IPV6, NH_NONE, 62, $urandom);
		queue_frame(ET_IPV4, PPP_IPV4, PROTO_TCP, 54, $urandom);
		queue_frame(ET_IPV4, PPP_IPV4, PROTO_TCP, 53, $urandom);
		queue_frame(ET_IPV4, PPP_IPV4, PROTO_UDP, 42, $urandom);
		queue_frame(ET_IPV4, PPP_IPV4, PROTO_UDP, 41, $urandom);
		queue_frame(ET_IPV4, PPP_IPV4, PROTO_ICMP, 60, $urandom);
		queue_frame(ET_IPV4, PPP_IPV4, NH_NONE, 60, $urandom);
		queue_frame(ET_IPV4, PPP_IPV4, PROTO_TCP, 33, $urandom);
		queue_frame(ET_IPV6, PPP_IPV6, PROTO_TCP, 74, $urandom);
		queue_frame(ET_IPV6, PPP_IPV6, PROTO_UDP, 62, $urandom);
		queue_frame(ET_IPV6, PPP_IPV6, NH_NONE, 54, $urandom);
		queue_frame(ET_IPV6, PPP_IPV6, NH_NONE, 53, $urandom);
		queue_frame(ET_UNKNOWN, PPP_IPV4, PROTO_TCP, 60, $urandom);
		queue_frame(16'hFFFF, PPP_IPV4, PROTO_TCP, 30, 32'hFFFF_FFFF);
		queue_frame(16'h0000, PPP_IPV4, PROTO_TCP, 20, 32'h0000_0000);
		queue_frame(ET_IPV4, PPP_IPV4, PROTO_TCP, 200, $urandom);

		// random frames: mostly well formed, some truncated, noise or long
		while (rand_bytes < RANDOM_BYTES || rand_frames < RANDOM_FRAMES) begin
			sel = $urandom_range(99);
			session = ($urandom_range(99) < 30);
			case ($urandom_range(9))
				0, 1, 2, 3: l3 = ET_IPV4;
				4, 5, 6, 7: l3 = ET_IPV6;
				8:          l3 = ET_ARP;
				default:    l3 = ET_PPP_DISC;
			endcase
			case ($urandom_range(99) / 5)
				0, 1, 2, 3, 4, 5, 6, 7, 8: l4 = PROTO_TCP;
				9, 10, 11, 12, 13, 14, 15: l4 = PROTO_UDP;
				16, 17:                    l4 = NH_NONE;
				default:                   l4 = 8'($urandom_range(255));
			endcase
			ppp_f = (l3 == ET_IPV4) ? PPP_IPV4 : (l3 == ET_IPV6) ? PPP_IPV6
				: 16'($urandom_range(16'hFFFF));
			etype_f = session ? ET_PPP_SES : l3;
			full = (session ? 22 : 14) + ((l3 == ET_IPV4) ? 20 : (l3 == ET_IPV6) ? 40 : 0)
				+ ((l4 == PROTO_UDP) ? 8 : 20);
			if (sel < 70) begin
				len = full + $urandom_range(12);
			end else if (sel < 85) begin
				len = $urandom_range(full, 1);
			end else if (sel < 97) begin
				etype_f = 16'($urandom_range(16'hFFFF));
				ppp_f   = 16'($urandom_range(16'hFFFF));
				len     = $urandom_range(90, 1);
			end else begin
				len = $urandom_range(180, 130);
			end
			queue_frame(etype_f, ppp_f, l4, len, $urandom);
			rand_bytes += len;
			rand_frames++;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every byte to go in and every result to come out
		while ((bytes_taken < total_bytes || expected_hdrs.size() > 0)
				&& cycle_cnt < CYCLE_LIMIT)
			@(posedge clk);

		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("packet_header_field_extractor: mismatch");
		end else begin
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (expected_hdrs.size() > 0)
				report_mismatch($sformatf("%0d frame results never arrived",
					expected_hdrs.size()));
			if (error_cnt == 0)
				$display("packet_header_field_extractor: match");
			else
				$display("packet_header_field_extractor: mismatch");
		end
		$finish;
	end

endmodule

/* files.f */
hdl/phfe_pkg.sv
hdl/phfe_ifs.sv
hdl/phfe_front.sv
hdl/phfe_queue.sv
hdl/phfe_back.sv
hdl/packet_header_field_extractor.sv
test/packet_header_field_extractor_tb.sv
